@@ rtl/midi_message_encoder_defines.svh @@
// assertion helpers for the midi encoder, clocked on clk_i and held off during reset
`ifndef MIDI_MESSAGE_ENCODER_DEFINES_SVH
`define MIDI_MESSAGE_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS
`define MME_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("midi encoder check failed");
`define MME_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("midi encoder check failed");
`else
`define MME_ASSERT_ALWAYS(lbl, cond)
`define MME_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/mme_pkg.sv @@
package mme_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] StatusNoteOn   = 8'h90;
  localparam logic [7:0] StatusNoteOff  = 8'h80;
  localparam logic [7:0] StatusCtrl     = 8'hB0;
  localparam logic [7:0] StatusPressure = 8'hD0;
  localparam logic [7:0] StatusBend     = 8'hE0;
  localparam logic [7:0] StatusProgram  = 8'hC0;
  localparam logic [7:0] ActiveSense    = 8'hFE;
  localparam logic [7:0] CcBreath       = 8'h02;
  localparam logic [7:0] CcExpression   = 8'h0B;
  localparam logic [7:0] CcVolume       = 8'h07;
  localparam logic [7:0] CcCutoff       = 8'd43;
  localparam logic [7:0] OnVelocity     = 8'd120;

  localparam logic [3:0] ChannelReset = 4'd1;

  typedef enum logic [2:0] {
    CMD_NOTE_ON  = 3'd0,
    CMD_NOTE_OFF = 3'd1,
    CMD_BEND     = 3'd2,
    CMD_LEVEL    = 3'd3,
    CMD_PROGRAM  = 3'd4,
    CMD_SENSE    = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    MODE_BREATH     = 3'd0,
    MODE_EXPRESSION = 3'd1,
    MODE_PRESSURE   = 3'd2,
    MODE_VOLUME     = 3'd3,
    MODE_CUTOFF     = 3'd4
  } ctl_mode_e;

  typedef enum logic [0:0] {
    CFG_CHANNEL = 1'b0,
    CFG_MODE    = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    JOB_NOTE_ON = 3'd0,
    JOB_RELEASE = 3'd1,
    JOB_BEND    = 3'd2,
    JOB_LEVEL   = 3'd3,
    JOB_PROGRAM = 3'd4,
    JOB_SENSE   = 3'd5
  } job_kind_e;

  // one classified command waiting for the byte sequencer
  typedef struct packed {
    job_kind_e   kind;
    logic        rel;       // send note off for rel_note first
    logic [6:0]  rel_note;
    logic [6:0]  data;      // note number or program number
    logic [6:0]  level;
    logic [13:0] v14;       // pitch bend, offset binary
  } job_t;

endpackage

@@ rtl/mme_front.sv @@
module mme_front import mme_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         command_i,
  input  logic [6:0]         note_i,
  input  logic [6:0]         level_i,
  input  logic signed [15:0] bend_i,
  input  logic [6:0]         program_req_i,
  input  logic               q_full_i,
  output logic               push_o,
  output job_t               job_o
);

  logic       sounding_q, sounding_d;
  logic [6:0] held_note_q, held_note_d;
  logic       accept;
  logic       produce;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept && produce;

  always_comb begin
    produce       = 1'b0;
    sounding_d    = sounding_q;
    held_note_d   = held_note_q;
    job_o.kind     = JOB_SENSE;
    job_o.rel      = 1'b0;
    job_o.rel_note = held_note_q;
    job_o.data     = note_i;
    job_o.level    = level_i;
    job_o.v14      = {~bend_i[15], bend_i[14:2]};
    unique case (command_i)
      CMD_NOTE_ON: begin
        produce     = 1'b1;
        job_o.kind  = JOB_NOTE_ON;
        job_o.rel   = sounding_q;
        sounding_d  = 1'b1;
        held_note_d = note_i;
      end
      CMD_NOTE_OFF: begin
        produce     = sounding_q;
        job_o.kind  = JOB_RELEASE;
        job_o.rel   = 1'b1;
        sounding_d  = 1'b0;
        held_note_d = '0;
      end
      CMD_BEND: begin
        produce    = sounding_q;
        job_o.kind = JOB_BEND;
      end
      CMD_LEVEL: begin
        produce    = 1'b1;
        job_o.kind = JOB_LEVEL;
      end
      CMD_PROGRAM: begin
        produce    = 1'b1;
        job_o.kind = JOB_PROGRAM;
        job_o.data = program_req_i;
      end
      CMD_SENSE: begin
        produce    = 1'b1;
        job_o.kind = JOB_SENSE;
      end
      default: begin
        // unused command codes are swallowed
        produce = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sounding_q  <= 1'b0;
      held_note_q <= '0;
    end else if (accept) begin
      sounding_q  <= sounding_d;
      held_note_q <= held_note_d;
    end
  end

endmodule

@@ rtl/mme_queue.sv @@
module mme_queue import mme_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  job_t                  entry_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_q, wr_d;
  logic [QueuePtrW-1:0]  rd_q, rd_d;
  logic [QueueCntW-1:0]  cnt_q, cnt_d;
  logic                  do_push;
  logic                  do_pop;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = entry_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= job_i;
    end
  end

endmodule

@@ rtl/mme_back.sv @@
module mme_back import mme_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [3:0] channel_i,
  input  logic [2:0] control_mode_i,
  input  logic       q_valid_i,
  input  job_t       q_job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] midi_byte_o,
  output logic       last_o
);

  logic       busy_q, busy_d;
  job_t       job_q;
  logic [3:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       advance;
  logic [7:0] cur_byte;
  logic       cur_last;
  logic [3:0] sub;
  logic [3:0] lvl_step;
  logic       in_level;
  logic [7:0] cc_num;
  logic [7:0] ch8;

  assign ch8         = {4'h0, channel_i};
  assign advance     = !out_valid_q || !out_stall_i;
  assign pop_o       = advance && (!busy_q || cur_last) && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign midi_byte_o = byte_q;
  assign last_o      = last_q;

  always_comb begin
    unique case (control_mode_i)
      MODE_BREATH: cc_num = CcBreath;
      MODE_VOLUME: cc_num = CcVolume;
      MODE_CUTOFF: cc_num = CcCutoff;
      default:     cc_num = CcExpression;
    endcase
  end

  // byte for the current step of the current job
  always_comb begin
    cur_byte = '0;
    cur_last = 1'b0;
    in_level = 1'b0;
    lvl_step = '0;
    sub      = step_q - (job_q.rel ? 4'd3 : 4'd0);
    if (job_q.rel && (step_q < 4'd3)) begin
      case (step_q[1:0])
        2'd0:    cur_byte = StatusNoteOff + ch8;
        2'd1:    cur_byte = {1'b0, job_q.rel_note};
        default: cur_byte = '0;
      endcase
      cur_last = (job_q.kind == JOB_RELEASE) && (step_q == 4'd2);
    end else begin
      unique case (job_q.kind)
        JOB_NOTE_ON: begin
          if (sub < 4'd3) begin
            case (sub[1:0])
              2'd0:    cur_byte = StatusNoteOn + ch8;
              2'd1:    cur_byte = {1'b0, job_q.data};
              default: cur_byte = OnVelocity;
            endcase
          end else begin
            in_level = 1'b1;
            lvl_step = sub - 4'd3;
          end
        end
        JOB_LEVEL: begin
          in_level = 1'b1;
          lvl_step = sub;
        end
        JOB_BEND: begin
          case (sub[1:0])
            2'd0:    cur_byte = StatusBend + ch8;
            2'd1:    cur_byte = {1'b0, job_q.v14[6:0]};
            default: cur_byte = {1'b0, job_q.v14[13:7]};
          endcase
          cur_last = (sub == 4'd2);
        end
        JOB_PROGRAM: begin
          cur_byte = (sub == 4'd0) ? StatusProgram + ch8 : {1'b0, job_q.data};
          cur_last = (sub == 4'd1);
        end
        JOB_SENSE: begin
          cur_byte = ActiveSense;
          cur_last = 1'b1;
        end
        default: begin
          // a release job never gets past its note off
          cur_last = 1'b1;
        end
      endcase
      if (in_level) begin
        if (control_mode_i == MODE_PRESSURE) begin
          cur_byte = (lvl_step == 4'd0) ? StatusPressure + ch8 : {1'b0, job_q.level};
          cur_last = (lvl_step == 4'd1);
        end else begin
          case (lvl_step[1:0])
            2'd0:    cur_byte = StatusCtrl + ch8;
            2'd1:    cur_byte = cc_num;
            default: cur_byte = {1'b0, job_q.level};
          endcase
          cur_last = (lvl_step == 4'd2);
        end
      end
    end
  end

  always_comb begin
    busy_d      = busy_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = busy_q;
      if (busy_q && !cur_last) begin
        step_d = step_q + 1'b1;
      end else begin
        busy_d = q_valid_i;
        step_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= q_job_i;
    end
    if (advance && busy_q) begin
      byte_q <= cur_byte;
      last_q <= cur_last;
    end
  end

endmodule

@@ rtl/midi_message_encoder.sv @@
// Serial MIDI channel-message encoder. Each command item turns into a burst of one to
// nine MIDI bytes on the output channel, one byte per cycle, with last_o set on the
// final byte of the burst; commands that make no bytes (note off or pitch bend while no
// note sounds, unused codes) vanish. The front end takes one item per cycle and keeps
// the sounding note; a two-entry job queue separates it from the byte sequencer, so
// input stalls only while the queue is full. Output throughput is one byte per cycle
// unless stalled, set by the sequencer, which goes straight on to a waiting job when
// a burst ends; a note on that first releases a held note is the longest burst at nine
// bytes. The channel and control mode registers are written through the config port,
// which is always ready; write them only while the block is idle.
`include "midi_message_encoder_defines.svh"

module midi_message_encoder import mme_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [0:0]         cfg_index_i,
  input  logic [3:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         command_i,
  input  logic [6:0]         note_i,
  input  logic [6:0]         level_i,
  input  logic signed [15:0] bend_i,
  input  logic [6:0]         program_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         midi_byte_o,
  output logic               last_o
);

  logic [3:0] channel_q;
  logic [2:0] control_mode_q;
  logic       q_push;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  job_t       push_job;
  job_t       head_job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_q      <= ChannelReset;
      control_mode_q <= MODE_BREATH;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CHANNEL: channel_q      <= cfg_data_i;
        CFG_MODE:    control_mode_q <= cfg_data_i[2:0];
        default:     channel_q      <= channel_q;
      endcase
    end
  end

  mme_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .note_i        (note_i),
    .level_i       (level_i),
    .bend_i        (bend_i),
    .program_req_i (program_req_i),
    .q_full_i      (q_full),
    .push_o        (q_push),
    .job_o         (push_job)
  );

  mme_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  mme_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .channel_i      (channel_q),
    .control_mode_i (control_mode_q),
    .q_valid_i      (q_valid),
    .q_job_i        (head_job),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .midi_byte_o    (midi_byte_o),
    .last_o         (last_o)
  );

  `MME_ASSERT_ALWAYS(a_no_push_when_full, !(q_push && q_full))
  `MME_ASSERT_ALWAYS(a_pop_only_when_valid, !q_pop || q_valid)
  `MME_ASSERT_NEXT(a_push_lands, q_push && !q_valid, q_valid)

endmodule
